// File: hdl/csm_pkg.sv
// Shared constants, command codes and control/status types for the stack machine.
`default_nettype none
package csm_pkg;
    localparam int StackDepthDefault = 1024;
    localparam int ValW = 31;
    localparam int DepW = 11;
    localparam int CmdW = 4;
    localparam logic signed [63:0] ValLimit = 64'sd1000000000;

    localparam logic [CmdW-1:0] CMD_START  = 4'd0;
    localparam logic [CmdW-1:0] CMD_NUM    = 4'd1;
    localparam logic [CmdW-1:0] CMD_POP    = 4'd2;
    localparam logic [CmdW-1:0] CMD_INV    = 4'd3;
    localparam logic [CmdW-1:0] CMD_DUP    = 4'd4;
    localparam logic [CmdW-1:0] CMD_SWP    = 4'd5;
    localparam logic [CmdW-1:0] CMD_ADD    = 4'd6;
    localparam logic [CmdW-1:0] CMD_SUB    = 4'd7;
    localparam logic [CmdW-1:0] CMD_MUL    = 4'd8;
    localparam logic [CmdW-1:0] CMD_DIV    = 4'd9;
    localparam logic [CmdW-1:0] CMD_MOD    = 4'd10;
    localparam logic [CmdW-1:0] CMD_FINISH = 4'd11;

    // Datapath operation selected by the controller for one step.
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_RDA  = 3'd1; // read top into a
    localparam logic [2:0] OP_RDB  = 3'd2; // read second into b
    localparam logic [2:0] OP_ALU  = 3'd3; // add/sub/mul into result
    localparam logic [2:0] OP_DIVS = 3'd4; // start divider
    localparam logic [2:0] OP_DIVI = 3'd5; // one divider step

    typedef struct packed {
        logic [2:0]          op;
        logic [CmdW-1:0]     cmd;
        logic                wr_en;     // write memory
        logic [1:0]          wr_src;    // 0 operand, 1 a, 2 b, 3 result
        logic                wr_below;  // write at sp-2 instead of sp-1 / sp
        logic                wr_push;   // write at sp
        logic                negate_a;  // write -a
    } csm_cmd_t;

    localparam logic [1:0] SRC_OPND = 2'd0;
    localparam logic [1:0] SRC_A    = 2'd1;
    localparam logic [1:0] SRC_B    = 2'd2;
    localparam logic [1:0] SRC_RES  = 2'd3;

    typedef struct packed {
        logic a_zero;
        logic res_oor;
        logic div_done;
        logic [ValW-1:0] top;
    } csm_stat_t;
endpackage
`default_nettype wire

// File: hdl/csm_datapath.sv
// Datapath: value stack memory, operand registers, ALU and iterative divider.
`default_nettype none
module csm_datapath
    import csm_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepthDefault,
    parameter int AW = $clog2(STACK_DEPTH)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire csm_cmd_t               cmd,
    input  wire logic [DepW+6-1:0]      sp,
    input  wire logic signed [ValW-1:0] operand,
    output csm_stat_t                   stat
);
    logic signed [ValW-1:0] mem [STACK_DEPTH];
    logic signed [ValW-1:0] rd_reg;
    logic signed [ValW-1:0] a_reg, b_reg;
    logic signed [63:0]     res_reg;
    logic [30:0] dq_reg, dd_reg;   // quotient/dividend shift, divisor magnitude
    logic [31:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic signed [ValW-1:0] wr_data;
    logic [30:0] mag_a, mag_b;
    logic [31:0] trial;

    assign mag_a = a_reg[ValW-1] ? 31'(-a_reg) : 31'(a_reg);
    assign mag_b = b_reg[ValW-1] ? 31'(-b_reg) : 31'(b_reg);

    always_comb begin
        rd_addr = (cmd.op == OP_RDB) ? AW'(sp - 2) : AW'(sp - 1);
        if (cmd.wr_push) wr_addr = AW'(sp);
        else if (cmd.wr_below) wr_addr = AW'(sp - 2);
        else wr_addr = AW'(sp - 1);
        case (cmd.wr_src)
            SRC_OPND: wr_data = operand;
            SRC_A:    wr_data = cmd.negate_a ? -a_reg : a_reg;
            SRC_B:    wr_data = b_reg;
            default:  wr_data = res_reg[ValW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    assign trial = {rem_reg[30:0], dq_reg[30]} - {1'b0, dd_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            case (cmd.op)
                OP_RDA: a_reg <= rd_reg;
                OP_RDB: b_reg <= rd_reg;
                OP_ALU: begin
                    case (cmd.cmd)
                        CMD_ADD: res_reg <= 64'(b_reg) + 64'(a_reg);
                        CMD_SUB: res_reg <= 64'(b_reg) - 64'(a_reg);
                        default: res_reg <= 64'(b_reg) * 64'(a_reg);
                    endcase
                end
                OP_DIVS: begin
                    dq_reg   <= mag_b;
                    dd_reg   <= mag_a;
                    rem_reg  <= '0;
                    cnt_reg  <= 5'd31;
                    busy_reg <= 1'b1;
                end
                OP_DIVI: begin
                    if (busy_reg) begin
                        if (!trial[31]) begin
                            rem_reg <= trial;
                            dq_reg  <= {dq_reg[29:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[30:0], dq_reg[30]};
                            dq_reg  <= {dq_reg[29:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 5'd1;
                        if (cnt_reg == 5'd1) busy_reg <= 1'b0;
                    end else begin
                        // Apply signs: quotient by sign xor, remainder by dividend.
                        if (cmd.cmd == CMD_DIV)
                            res_reg <= (a_reg[ValW-1] ^ b_reg[ValW-1]) ?
                                -64'(dq_reg) : 64'(dq_reg);
                        else
                            res_reg <= b_reg[ValW-1] ? -64'(rem_reg) : 64'(rem_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    assign stat.a_zero   = (a_reg == '0);
    assign stat.res_oor  = (res_reg > ValLimit) || (res_reg < -ValLimit);
    assign stat.div_done = !busy_reg;
    assign stat.top      = rd_reg;
endmodule
`default_nettype wire

// File: hdl/csm_ctrl.sv
// Controller: command sequencing, stack pointer, sticky error and result register.
`default_nettype none
module csm_ctrl
    import csm_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepthDefault
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [CmdW-1:0] in_cmd,
    input  wire logic signed [ValW-1:0] in_opnd,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [DepW+6-1:0]    sp,
    output logic signed [ValW-1:0] opnd,
    output csm_cmd_t             dcmd,
    input  wire csm_stat_t       stat,
    output logic                 o_err,
    output logic [DepW-1:0]      o_depth,
    output logic [ValW-1:0]      o_top,
    output logic                 o_fin
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RDA = 3'd1, S_RDB = 3'd2, S_EXEC = 3'd3,
                           S_DIV = 3'd4, S_WR = 3'd5, S_TOP = 3'd6, S_OUT = 3'd7;
    localparam int SpW = DepW + 6;
    localparam logic [SpW-1:0] Full = SpW'(STACK_DEPTH);

    logic [2:0] state_reg, state_next;
    logic [SpW-1:0] sp_reg, sp_next;
    logic err_reg, err_next, fin_reg, fin_next;
    logic [CmdW-1:0] cmd_reg, cmd_next;
    logic signed [ValW-1:0] opnd_reg, opnd_next;
    logic out_valid_reg;
    logic [ValW-1:0] top_reg;
    logic [DepW-1:0] depth_reg;
    logic err_o_reg, fin_o_reg;
    logic oor_opnd;

    assign sp = sp_reg;
    assign opnd = opnd_reg;
    assign oor_opnd = (64'(opnd_reg) > ValLimit) || (64'(opnd_reg) < -ValLimit);
    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        sp_next = sp_reg;
        err_next = err_reg;
        fin_next = fin_reg;
        cmd_next = cmd_reg;
        opnd_next = opnd_reg;
        dcmd = '0;
        dcmd.cmd = cmd_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next = in_cmd;
                    opnd_next = in_opnd;
                    fin_next = 1'b0;
                    state_next = S_RDA;
                end
            end
            S_RDA: begin
                // Top is in the read register; decide what the command needs.
                if (cmd_reg == CMD_START) begin
                    // Empty the stack first so the start value lands at the bottom.
                    sp_next = '0;
                    err_next = oor_opnd;
                    state_next = S_WR;
                end else if (cmd_reg == CMD_FINISH) begin
                    fin_next = (sp_reg == SpW'(1)) && !err_reg;
                    state_next = S_TOP;
                end else if (cmd_reg > CMD_FINISH || err_reg) begin
                    state_next = S_TOP;
                end else if (cmd_reg == CMD_NUM) begin
                    if (sp_reg >= Full) err_next = 1'b1;
                    else begin
                        dcmd.wr_en = 1'b1; dcmd.wr_push = 1'b1; dcmd.wr_src = SRC_OPND;
                        sp_next = sp_reg + 1'b1;
                        err_next = oor_opnd;
                    end
                    state_next = S_TOP;
                end else if (sp_reg == '0) begin
                    err_next = 1'b1;
                    state_next = S_TOP;
                end else if (cmd_reg == CMD_POP) begin
                    sp_next = sp_reg - 1'b1;
                    err_next = (sp_reg == SpW'(1));
                    state_next = S_TOP;
                end else begin
                    dcmd.op = OP_RDA;
                    state_next = S_RDB;
                end
            end
            S_RDB: begin
                dcmd.op = OP_RDB;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                // a holds top; load b from sp-2.
                dcmd.op = OP_RDB;
                state_next = S_WR;
                if (cmd_reg == CMD_INV) begin
                    state_next = S_WR;
                end else if (cmd_reg == CMD_DUP) begin
                    if (sp_reg >= Full) begin
                        err_next = 1'b1;
                        state_next = S_TOP;
                    end
                end else if ((cmd_reg == CMD_DIV || cmd_reg == CMD_MOD) && stat.a_zero) begin
                    err_next = 1'b1;
                    state_next = S_TOP;
                end else if (sp_reg == SpW'(1)) begin
                    sp_next = '0;
                    err_next = 1'b1;
                    state_next = S_TOP;
                end else if (cmd_reg == CMD_DIV || cmd_reg == CMD_MOD) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                dcmd.op = OP_DIVS;
                state_next = S_WR;
            end
            S_WR: begin
                case (cmd_reg)
                    CMD_START: begin
                        dcmd.wr_en = 1'b1; dcmd.wr_push = 1'b1; dcmd.wr_src = SRC_OPND;
                        sp_next = SpW'(1);
                        state_next = S_TOP;
                    end
                    CMD_INV: begin
                        dcmd.wr_en = 1'b1; dcmd.wr_src = SRC_A; dcmd.negate_a = 1'b1;
                        state_next = S_TOP;
                    end
                    CMD_DUP: begin
                        dcmd.wr_en = 1'b1; dcmd.wr_push = 1'b1; dcmd.wr_src = SRC_A;
                        sp_next = sp_reg + 1'b1;
                        state_next = S_TOP;
                    end
                    CMD_SWP: begin
                        dcmd.wr_en = 1'b1; dcmd.wr_below = 1'b1; dcmd.wr_src = SRC_A;
                        cmd_next = CMD_FINISH + 4'd1; // mark a second write pass, b to the top
                        state_next = S_OUT;
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL: begin
                        dcmd.op = OP_ALU;
                        state_next = S_OUT;
                    end
                    default: begin
                        // Divide: iterate until done, then form signed result.
                        dcmd.op = OP_DIVI;
                        if (stat.div_done) state_next = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                if (cmd_reg == CMD_FINISH + 4'd1) begin
                    dcmd.wr_en = 1'b1; dcmd.wr_src = SRC_B;
                    cmd_next = CMD_SWP;
                    state_next = S_TOP;
                end else if (stat.res_oor) begin
                    err_next = 1'b1;
                    state_next = S_TOP;
                end else begin
                    dcmd.wr_en = 1'b1; dcmd.wr_below = 1'b1; dcmd.wr_src = SRC_RES;
                    sp_next = sp_reg - 1'b1;
                    state_next = S_TOP;
                end
            end
            default: begin
                // S_TOP: read top of the final stack, then present result.
                if (!out_valid_reg || out_ready) state_next = S_IDLE;
            end
        endcase
    end

    // Top read pipeline: address set in S_TOP, read data registered and valid in the next cycle.
    logic top_pend_reg;
    logic load_out;

    assign load_out = (state_reg == S_TOP) && top_pend_reg &&
                      (!out_valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
            err_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            top_pend_reg <= 1'b0;
        end else begin
            sp_reg <= sp_next;
            err_reg <= err_next;
            if (load_out) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
            if (state_reg == S_TOP) begin
                if (!top_pend_reg) begin
                    top_pend_reg <= 1'b1;
                end else if (load_out) begin
                    top_pend_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
            end else begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        opnd_reg <= opnd_next;
        fin_reg <= fin_next;
        if (load_out) begin
            top_reg <= (sp_reg == '0) ? '0 : stat.top;
            depth_reg <= DepW'(sp_reg);
            err_o_reg <= err_reg;
            fin_o_reg <= fin_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign o_err = err_o_reg;
    assign o_depth = depth_reg;
    assign o_top = top_reg;
    assign o_fin = fin_o_reg;
endmodule
`default_nettype wire

// File: hdl/checked_integer_stack_machine.sv
// Top level of the checked integer stack machine.
`default_nettype none
// One request in, one result out per command. NUM, POP, FINISH, unknown
// commands and commands that find the error set or the stack empty go
// straight to reading the top, and START to its write; the others first
// load the operands, and DIV and MOD then run the radix-2 restoring divider
// (31 quotient bits, one a cycle, then a step to apply the signs). The
// stack lives in a single-port-write, registered-read memory of STACK_DEPTH
// words, and needs no clearing pass. A result still waiting in the output
// register does not block the next request; that command runs and holds
// at its last step until m_tready frees the register.
module checked_integer_stack_machine
    import csm_pkg::*;
#(
    parameter int STACK_DEPTH = StackDepthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // command[3:0], operand[34:4]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata   // error_flag[0], stack_depth[11:1],
                                       // top_value[42:12], final_ok[43]
);
    csm_cmd_t  dcmd;
    csm_stat_t stat;
    logic [DepW+6-1:0] sp;
    logic signed [ValW-1:0] opnd;
    logic o_err, o_fin;
    logic [DepW-1:0] o_depth;
    logic [ValW-1:0] o_top;

    csm_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[3:0]), .in_opnd(s_tdata[34:4]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .sp(sp), .opnd(opnd), .dcmd(dcmd), .stat(stat),
        .o_err(o_err), .o_depth(o_depth), .o_top(o_top), .o_fin(o_fin)
    );

    csm_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(dcmd), .sp(sp),
        .operand(opnd), .stat(stat)
    );

    assign m_tdata = {4'b0, o_fin, o_top, o_depth, o_err};
endmodule
`default_nettype wire
